// ===== rtl/core/ray_triangle_intersection_assert.svh =====
// Assertion macros for the ray-triangle intersection checker
`ifndef RAY_TRIANGLE_INTERSECTION_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECTION_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define RTI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is low
`define RTI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/core/rti_pkg.sv =====
// Types and constants of the ray-triangle intersection pipeline
`timescale 1ns / 1ps
package rti_pkg;

    localparam int COORD_W    = 32;
    localparam int TOL_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    // Width of the exact dot products (triple products need 102 bits)
    localparam int DW         = 104;
    // Width of the divider remainder (det shifted by 31 needs 133 bits)
    localparam int RW         = 134;
    // Quotient bits, including the saturation position
    localparam int QW         = 32;
    localparam logic [QW-1:0] DIST_SAT = 32'h7FFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_ORIGIN_Z,
        REG_DIR_X,
        REG_DIR_Y,
        REG_DIR_Z,
        REG_TOLERANCE
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] v0_x;
        logic signed [COORD_W-1:0] v0_y;
        logic signed [COORD_W-1:0] v0_z;
        logic signed [COORD_W-1:0] v1_x;
        logic signed [COORD_W-1:0] v1_y;
        logic signed [COORD_W-1:0] v1_z;
        logic signed [COORD_W-1:0] v2_x;
        logic signed [COORD_W-1:0] v2_y;
        logic signed [COORD_W-1:0] v2_z;
    } in_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] distance;
    } out_t;

    // One divider stage worth of state
    typedef struct packed {
        logic          hit;
        logic          sat;
        logic [QW-1:0] quo;
        logic [RW-1:0] rem;
        logic [DW-1:0] det;
    } dv_t;

endpackage

// ===== rtl/core/ray_triangle_intersection.sv =====
// Throughput: one triangle per cycle unless the output stalls a full pipeline;
// 11 arithmetic stages feed a 32-stage restoring divider: a saturation
// check, then one quotient bit per stage.
// Empty stages are filled while later stages stall, so bubbles collapse.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the ray
// registers with origin 0, direction +z and tolerance 66.
`timescale 1ns / 1ps
module ray_triangle_intersection #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [rti_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  rti_pkg::in_t                     in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output rti_pkg::out_t                    out_data
);
    import rti_pkg::*;

    localparam int NPRE = 11;
    localparam int NDIV = QW;
    localparam int NS   = NPRE + NDIV;
    localparam int CW   = 120 + FRAC_BITS;
    localparam logic [COORD_W-1:0] DIR_Z_RESET = COORD_W'(64'd1 << FRAC_BITS);

    // Ray registers
    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [COORD_W-1:0] dir_reg [3];
    logic [TOL_W-1:0]          tol_reg;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= DIR_Z_RESET;
            tol_reg    <= TOL_W'(66);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ORIGIN_X:  org_reg[0] <= cfg_data;
                REG_ORIGIN_Y:  org_reg[1] <= cfg_data;
                REG_ORIGIN_Z:  org_reg[2] <= cfg_data;
                REG_DIR_X:     dir_reg[0] <= cfg_data;
                REG_DIR_Y:     dir_reg[1] <= cfg_data;
                REG_DIR_Z:     dir_reg[2] <= cfg_data;
                REG_TOLERANCE: tol_reg    <= cfg_data[TOL_W-1:0];
                default:       ;
            endcase
        end
    end

    // Pipeline flow control: a stage advances when the output is ready or it or any later stage has a hole
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_in;
    logic [NS-1:0] adv;

    assign vld_in = {vld_reg[NS-2:0], in_valid};

    for (genvar k = 0; k < NS; k++)
    begin : g_adv
        assign adv[k] = out_ready || !(&vld_reg[NS-1:k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NS-1];

    // Stage 1: edges and origin offset
    logic signed [COORD_W-1:0] vt0 [3];
    logic signed [COORD_W-1:0] vt1 [3];
    logic signed [COORD_W-1:0] vt2 [3];
    logic signed [COORD_W:0]   s1_e1_next [3];
    logic signed [COORD_W:0]   s1_e2_next [3];
    logic signed [COORD_W:0]   s1_s_next  [3];
    logic signed [COORD_W:0]   s1_e1_reg  [3];
    logic signed [COORD_W:0]   s1_e2_reg  [3];
    logic signed [COORD_W:0]   s1_s_reg   [3];

    always_comb
    begin
        vt0[0] = in_data.v0_x;
        vt0[1] = in_data.v0_y;
        vt0[2] = in_data.v0_z;
        vt1[0] = in_data.v1_x;
        vt1[1] = in_data.v1_y;
        vt1[2] = in_data.v1_z;
        vt2[0] = in_data.v2_x;
        vt2[1] = in_data.v2_y;
        vt2[2] = in_data.v2_z;
        for (int i = 0; i < 3; i++)
        begin
            s1_e1_next[i] = (COORD_W+1)'(vt1[i]) - (COORD_W+1)'(vt0[i]);
            s1_e2_next[i] = (COORD_W+1)'(vt2[i]) - (COORD_W+1)'(vt0[i]);
            s1_s_next[i]  = (COORD_W+1)'(org_reg[i]) - (COORD_W+1)'(vt0[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_e1_reg <= s1_e1_next;
            s1_e2_reg <= s1_e2_next;
            s1_s_reg  <= s1_s_next;
        end
    end

    // Stage 2: cross product terms, p = dir x e2 and q = s x e1
    logic signed [64:0]      s2_pm_next [6];
    logic signed [65:0]      s2_qm_next [6];
    logic signed [64:0]      s2_pm_reg  [6];
    logic signed [65:0]      s2_qm_reg  [6];
    logic signed [COORD_W:0] s2_e1_reg  [3];
    logic signed [COORD_W:0] s2_e2_reg  [3];
    logic signed [COORD_W:0] s2_s_reg   [3];

    always_comb
    begin
        s2_pm_next[0] = dir_reg[1] * s1_e2_reg[2];
        s2_pm_next[1] = dir_reg[2] * s1_e2_reg[1];
        s2_pm_next[2] = dir_reg[2] * s1_e2_reg[0];
        s2_pm_next[3] = dir_reg[0] * s1_e2_reg[2];
        s2_pm_next[4] = dir_reg[0] * s1_e2_reg[1];
        s2_pm_next[5] = dir_reg[1] * s1_e2_reg[0];
        s2_qm_next[0] = s1_s_reg[1] * s1_e1_reg[2];
        s2_qm_next[1] = s1_s_reg[2] * s1_e1_reg[1];
        s2_qm_next[2] = s1_s_reg[2] * s1_e1_reg[0];
        s2_qm_next[3] = s1_s_reg[0] * s1_e1_reg[2];
        s2_qm_next[4] = s1_s_reg[0] * s1_e1_reg[1];
        s2_qm_next[5] = s1_s_reg[1] * s1_e1_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_pm_reg <= s2_pm_next;
            s2_qm_reg <= s2_qm_next;
            s2_e1_reg <= s1_e1_reg;
            s2_e2_reg <= s1_e2_reg;
            s2_s_reg  <= s1_s_reg;
        end
    end

    // Stage 3: finish the cross products
    logic signed [65:0]      s3_p_next [3];
    logic signed [66:0]      s3_q_next [3];
    logic signed [65:0]      s3_p_reg  [3];
    logic signed [66:0]      s3_q_reg  [3];
    logic signed [COORD_W:0] s3_e1_reg [3];
    logic signed [COORD_W:0] s3_e2_reg [3];
    logic signed [COORD_W:0] s3_s_reg  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_p_next[i] = 66'(s2_pm_reg[2*i]) - 66'(s2_pm_reg[2*i+1]);
            s3_q_next[i] = 67'(s2_qm_reg[2*i]) - 67'(s2_qm_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_p_reg  <= s3_p_next;
            s3_q_reg  <= s3_q_next;
            s3_e1_reg <= s2_e1_reg;
            s3_e2_reg <= s2_e2_reg;
            s3_s_reg  <= s2_s_reg;
        end
    end

    // Stage 4: dot product terms, each split into a low and a high half
    // Terms 0-2 det = e1.p, 3-5 u = s.p, 6-8 v = dir.q, 9-11 t = e2.q
    logic signed [COORD_W:0] a_op [12];
    logic signed [66:0]      b_op [12];
    logic signed [67:0]      s4_lo_next [12];
    logic signed [65:0]      s4_hi_next [12];
    logic signed [67:0]      s4_lo_reg  [12];
    logic signed [65:0]      s4_hi_reg  [12];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_op[i]   = s3_e1_reg[i];
            b_op[i]   = 67'(s3_p_reg[i]);
            a_op[3+i] = s3_s_reg[i];
            b_op[3+i] = 67'(s3_p_reg[i]);
            a_op[6+i] = (COORD_W+1)'(dir_reg[i]);
            b_op[6+i] = s3_q_reg[i];
            a_op[9+i] = s3_e2_reg[i];
            b_op[9+i] = s3_q_reg[i];
        end
        for (int j = 0; j < 12; j++)
        begin
            s4_lo_next[j] = a_op[j] * $signed({1'b0, b_op[j][33:0]});
            s4_hi_next[j] = a_op[j] * $signed(b_op[j][66:34]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_lo_reg <= s4_lo_next;
            s4_hi_reg <= s4_hi_next;
        end
    end

    // Stage 5: merge the halves of each term
    logic signed [DW-1:0] s5_prod_next [12];
    logic signed [DW-1:0] s5_prod_reg  [12];

    always_comb
    begin
        for (int j = 0; j < 12; j++)
        begin
            s5_prod_next[j] = (DW'(s4_hi_reg[j]) <<< 34) + DW'(s4_lo_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_prod_reg <= s5_prod_next;
        end
    end

    // Stage 6: sum the terms into det, u, v and t numerators
    logic signed [DW-1:0] s6_dot_next [4];
    logic signed [DW-1:0] s6_dot_reg  [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            s6_dot_next[k] = s5_prod_reg[3*k] + s5_prod_reg[3*k+1] + s5_prod_reg[3*k+2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s6_dot_reg <= s6_dot_next;
        end
    end

    // Stage 7: flip all signs so that det is not negative
    logic signed [DW-1:0] s7_nrm_next [4];
    logic signed [DW-1:0] s7_nrm_reg  [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            s7_nrm_next[k] = s6_dot_reg[0][DW-1] ? -s6_dot_reg[k] : s6_dot_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s7_nrm_reg <= s7_nrm_next;
        end
    end

    // Stage 8: tolerance times det, in 26-bit slices of det
    logic [DW-1:0]        det_u;
    logic [41:0]          s8_mt_next [4];
    logic [41:0]          s8_mt_reg  [4];
    logic signed [DW-1:0] s8_nrm_reg [4];

    always_comb
    begin
        det_u = s7_nrm_reg[0];
        for (int j = 0; j < 4; j++)
        begin
            s8_mt_next[j] = tol_reg * det_u[26*j +: 26];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s8_mt_reg  <= s8_mt_next;
            s8_nrm_reg <= s7_nrm_reg;
        end
    end

    // Stage 9: assemble tolerance times det
    logic [CW-1:0]        s9_told_next;
    logic [CW-1:0]        s9_told_reg;
    logic signed [DW-1:0] s9_nrm_reg [4];

    assign s9_told_next = CW'(s8_mt_reg[0]) + (CW'(s8_mt_reg[1]) << 26)
                        + (CW'(s8_mt_reg[2]) << 52) + (CW'(s8_mt_reg[3]) << 78);

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            s9_told_reg <= s9_told_next;
            s9_nrm_reg  <= s8_nrm_reg;
        end
    end

    // Stage 10: bounds for the barycentric tests and the u + v sum
    logic signed [CW-1:0] told_s;
    logic signed [CW-1:0] s10_negt_next;
    logic signed [CW-1:0] s10_onet_next;
    logic signed [CW-1:0] s10_uv_next;
    logic signed [CW-1:0] s10_told_reg;
    logic signed [CW-1:0] s10_negt_reg;
    logic signed [CW-1:0] s10_onet_reg;
    logic signed [CW-1:0] s10_uv_reg;
    logic signed [DW-1:0] s10_nrm_reg [4];

    always_comb
    begin
        told_s        = $signed(s9_told_reg);
        s10_negt_next = -told_s;
        s10_onet_next = (CW'(s9_nrm_reg[0]) <<< FRAC_BITS) + told_s;
        s10_uv_next   = CW'(s9_nrm_reg[1]) + CW'(s9_nrm_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            s10_told_reg <= told_s;
            s10_negt_reg <= s10_negt_next;
            s10_onet_reg <= s10_onet_next;
            s10_uv_reg   <= s10_uv_next;
            s10_nrm_reg  <= s9_nrm_reg;
        end
    end

    // Stage 11: accept or reject, and load the divider
    logic signed [CW-1:0] det_w;
    logic signed [CW-1:0] un_w;
    logic signed [CW-1:0] vn_w;
    logic signed [CW-1:0] tn_w;
    logic signed [CW-1:0] uv_w;
    logic signed [CW-1:0] det_min;
    logic                 hit_c;
    dv_t                  s11_next;
    dv_t                  s11_reg;

    always_comb
    begin
        det_w   = CW'(s10_nrm_reg[0]);
        un_w    = CW'(s10_nrm_reg[1]) <<< FRAC_BITS;
        vn_w    = CW'(s10_nrm_reg[2]) <<< FRAC_BITS;
        tn_w    = CW'(s10_nrm_reg[3]) <<< FRAC_BITS;
        uv_w    = s10_uv_reg <<< FRAC_BITS;
        det_min = $signed(CW'(tol_reg)) <<< (2 * FRAC_BITS);
        hit_c   = (det_w != '0) && (det_w >= det_min)
                && (un_w >= s10_negt_reg) && (un_w <= s10_onet_reg)
                && (vn_w >= s10_negt_reg) && (uv_w <= s10_onet_reg)
                && (tn_w > s10_told_reg);
        s11_next.hit = hit_c;
        s11_next.sat = 1'b0;
        s11_next.quo = '0;
        s11_next.rem = RW'(s10_nrm_reg[3]) << FRAC_BITS;
        s11_next.det = s10_nrm_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[10])
        begin
            s11_reg <= s11_next;
        end
    end

    // Divider: the first stage checks saturation, the rest give one bit each
    dv_t dv_in   [NDIV];
    dv_t dv_next [NDIV];
    dv_t div_reg [NDIV];

    always_comb
    begin
        logic [RW-1:0] sub;
        dv_in[0] = s11_reg;
        for (int j = 1; j < NDIV; j++)
        begin
            dv_in[j] = div_reg[j-1];
        end
        for (int j = 0; j < NDIV; j++)
        begin
            dv_next[j] = dv_in[j];
            sub = RW'(dv_in[j].det) << (QW - 1 - j);
            if (j == 0)
            begin
                if (dv_in[j].rem >= sub)
                begin
                    dv_next[j].sat = 1'b1;
                    dv_next[j].quo = DIST_SAT;
                end
            end
            else if (!dv_in[j].sat && dv_in[j].rem >= sub)
            begin
                dv_next[j].rem = dv_in[j].rem - sub;
                dv_next[j].quo[QW-1-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NDIV; j++)
        begin
            if (adv[NPRE+j])
            begin
                div_reg[j] <= dv_next[j];
            end
        end
    end

    // Drive the result transaction; a miss reports zero distance
    assign out_data.hit      = div_reg[NDIV-1].hit;
    assign out_data.distance = div_reg[NDIV-1].hit ? $signed(div_reg[NDIV-1].quo) : '0;

endmodule

// ===== rtl/core/rti_checker.sv =====
// Port-level checker for the ray-triangle intersection block, with its bind
`timescale 1ns / 1ps
`include "ray_triangle_intersection_assert.svh"
module rti_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input rti_pkg::out_t out_data
);
    import rti_pkg::*;

    // Hold a stalled result transaction
    `RTI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    // Never stall the input while the output drains
    `RTI_ASSERT_IMP(a_ready_flow, clk, rst_n, out_ready, in_ready)
    // Report zero distance on a miss
    `RTI_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !out_data.hit, out_data.distance == '0)
    // Report a positive distance on a hit
    `RTI_ASSERT_IMP(a_hit_pos, clk, rst_n, out_valid && out_data.hit, !out_data.distance[COORD_W-1])

endmodule

bind ray_triangle_intersection rti_checker u_rti_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
